// ===== design/greedy_word_wrap_unit_assert.svh =====
// assertion macros used by the word wrap datapath rtl
`ifndef GREEDY_WORD_WRAP_UNIT_ASSERT_SVH
`define GREEDY_WORD_WRAP_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GWW_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define GWW_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/gww_pkg.sv =====
// types, codes and helpers for the greedy word wrap unit
`default_nettype none

package gww_pkg;

  localparam int SUM_W  = 13;
  localparam int COST_W = 9;
  localparam int CHAR_W = 8;
  localparam int LW_W   = 12;
  localparam int SPC_W  = 4;

  localparam logic [CHAR_W-1:0] CODE_END = 8'd0;
  localparam logic [CHAR_W-1:0] CODE_NL  = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_SP  = 8'd32;

  localparam logic REG_LINE_WIDTH   = 1'b0;
  localparam logic REG_CHAR_SPACING = 1'b1;

  localparam logic [LW_W-1:0]  LINE_WIDTH_RST   = 12'd640;
  localparam logic [SPC_W-1:0] CHAR_SPACING_RST = 4'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SLOT,
    ST_DEMIT
  } gww_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic load_pre;
    logic rd_issue;
    logic load_dump;
    logic load_fin;
  } gww_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pre_pend;
    logic dump_left;
    logic fin_pend;
    logic out_free;
  } gww_sts_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [COST_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {{(SUM_W+1-COST_W){1'b0}}, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/gww_ram.sv =====
// generic single-port-write ram with registered read
`default_nettype none

module gww_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/gww_ctrl.sv =====
// controller: sequences accept, prefix, held word release and final char
`default_nettype none

module gww_ctrl import gww_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire gww_sts_t sts,
  output gww_cmd_t      cmd
);

  gww_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_SLOT;
      end
      ST_SLOT: begin
        if (sts.pre_pend) begin
          state_nxt = ST_SLOT;
        end else if (sts.dump_left) begin
          state_nxt = ST_DEMIT;
        end else if (sts.fin_pend) begin
          if (sts.out_free) state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DEMIT: begin
        if (sts.out_free) state_nxt = ST_SLOT;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      ST_SLOT: begin
        cmd.load_pre = sts.pre_pend && sts.out_free;
        cmd.rd_issue = !sts.pre_pend && sts.dump_left;
        cmd.load_fin = !sts.pre_pend && !sts.dump_left && sts.fin_pend && sts.out_free;
      end
      ST_DEMIT: begin
        cmd.load_dump = sts.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/gww_dp.sv =====
// datapath: line sums, hold store, break decision and output register
`default_nettype none

`include "greedy_word_wrap_unit_assert.svh"

module gww_dp import gww_pkg::*; #(
  parameter int HOLD_DEPTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_addr,
  input  wire logic [LW_W-1:0]    cfg_wr_data,
  input  wire logic [15:0]        in_tdata,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic      [CHAR_W-1:0]  out_tdata,
  output logic                    out_tlast,
  input  wire gww_cmd_t           cmd,
  output gww_sts_t                sts
);

  localparam int AW = $clog2(HOLD_DEPTH);
  localparam int CW = $clog2(HOLD_DEPTH + 1);

  // configuration
  logic [LW_W-1:0]  line_width_r;
  logic [SPC_W-1:0] char_spacing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= LINE_WIDTH_RST;
      char_spacing_r <= CHAR_SPACING_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_LINE_WIDTH:   line_width_r   <= cfg_wr_data;
        REG_CHAR_SPACING: char_spacing_r <= cfg_wr_data[SPC_W-1:0];
        default:          line_width_r   <= line_width_r;
      endcase
    end
  end

  // line state
  logic [SUM_W-1:0]  line_sum_r, line_sum_nxt;
  logic              has_brk_r, has_brk_nxt;
  logic              sp_pend_r, sp_pend_nxt;
  logic [CW-1:0]     held_cnt_r, held_cnt_nxt;
  logic [SUM_W-1:0]  held_sum_r, held_sum_nxt;

  // emission plan
  logic              pre_pend_r;
  logic [CHAR_W-1:0] pre_char_r;
  logic              fin_pend_r;
  logic [CHAR_W-1:0] fin_char_r;
  logic [CW-1:0]     dump_cnt_r;
  logic [CW-1:0]     idx_r;

  // output register
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_data_r;
  logic              out_last_r;

  // decision on the incoming beat
  logic [CHAR_W-1:0] code;
  logic [COST_W-1:0] cost;
  logic              is_end, is_nl, is_sp, is_ord;
  logic              brk1, brk2, sp_a, dump, hold, pre_en, fin_en;
  logic [SUM_W-1:0]  ls_a, ls_b;
  logic [CHAR_W-1:0] pre_char;

  always_comb begin
    code   = in_tdata[7:0];
    cost   = {1'b0, in_tdata[15:8]} + {{(COST_W-SPC_W){1'b0}}, char_spacing_r};
    is_end = (code == CODE_END);
    is_nl  = (code == CODE_NL);
    is_sp  = (code == CODE_SP);
    is_ord = !is_end && !is_nl && !is_sp;

    // overlong line with a break point: held space turns into a newline
    brk1 = has_brk_r && (line_sum_r > {1'b0, line_width_r});
    sp_a = brk1 ? 1'b0 : sp_pend_r;
    ls_a = brk1 ? held_sum_r : line_sum_r;
    // hold store full forces an early break
    brk2 = is_ord && sp_a && (held_cnt_r >= CW'(HOLD_DEPTH));
    ls_b = brk2 ? held_sum_r : ls_a;
    dump = brk1 || !is_ord || brk2;
    hold = is_ord && sp_a && !brk2;

    pre_en   = brk1 ? sp_pend_r : (is_ord ? brk2 : sp_pend_r);
    pre_char = (brk1 || brk2) ? CODE_NL : CODE_SP;
    fin_en   = !is_sp && !hold;

    line_sum_nxt = (is_end || is_nl) ? '0 : sat_add(ls_b, cost);
    if (is_sp) begin
      has_brk_nxt = 1'b1;
    end else if (is_end || is_nl || brk1 || brk2) begin
      has_brk_nxt = 1'b0;
    end else begin
      has_brk_nxt = has_brk_r;
    end
    sp_pend_nxt  = is_sp || hold;
    held_cnt_nxt = dump ? '0 : (hold ? held_cnt_r + CW'(1) : held_cnt_r);
    held_sum_nxt = dump ? '0 : (hold ? sat_add(held_sum_r, cost) : held_sum_r);
  end

  // hold store
  logic [CHAR_W-1:0] rd_data;

  gww_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (HOLD_DEPTH)
  ) u_hold (
    .clk     (clk),
    .wr_en   (cmd.accept && hold),
    .wr_addr (held_cnt_r[AW-1:0]),
    .wr_data (code),
    .rd_en   (cmd.rd_issue),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  logic [CW-1:0] idx_inc;
  logic          dump_left;
  logic          out_free;
  logic [2:0]    out_loads;
  logic          out_load;

  assign idx_inc   = idx_r + CW'(1);
  assign dump_left = idx_r < dump_cnt_r;
  assign out_free  = !out_valid_r || out_tready;
  assign out_loads = {cmd.load_pre, cmd.load_dump, cmd.load_fin};
  assign out_load  = |out_loads;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_sum_r <= '0;
      has_brk_r  <= 1'b0;
      sp_pend_r  <= 1'b0;
      held_cnt_r <= '0;
      held_sum_r <= '0;
      pre_pend_r <= 1'b0;
      fin_pend_r <= 1'b0;
      dump_cnt_r <= '0;
      idx_r      <= '0;
    end else begin
      if (cmd.accept) begin
        line_sum_r <= line_sum_nxt;
        has_brk_r  <= has_brk_nxt;
        sp_pend_r  <= sp_pend_nxt;
        held_cnt_r <= held_cnt_nxt;
        held_sum_r <= held_sum_nxt;
        pre_pend_r <= pre_en;
        fin_pend_r <= fin_en;
        dump_cnt_r <= dump ? held_cnt_r : '0;
        idx_r      <= '0;
      end
      if (cmd.load_pre)  pre_pend_r <= 1'b0;
      if (cmd.load_fin)  fin_pend_r <= 1'b0;
      if (cmd.load_dump) idx_r      <= idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pre_char_r <= pre_char;
      fin_char_r <= code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pre) begin
      out_data_r <= pre_char_r;
      out_last_r <= !dump_left && !fin_pend_r;
    end else if (cmd.load_dump) begin
      out_data_r <= rd_data;
      out_last_r <= (idx_inc == dump_cnt_r) && !fin_pend_r;
    end else if (cmd.load_fin) begin
      out_data_r <= fin_char_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assign sts.pre_pend  = pre_pend_r;
  assign sts.dump_left = dump_left;
  assign sts.fin_pend  = fin_pend_r;
  assign sts.out_free  = out_free;

  `GWW_CHECK(a_held_bound, 1'b1, held_cnt_r <= CW'(HOLD_DEPTH), "held count beyond store depth")
  `GWW_CHECK(a_idx_bound, 1'b1, idx_r <= dump_cnt_r, "release index past held word")
  `GWW_CHECK(a_brk_needs_space, has_brk_r, sp_pend_r, "break point without held space")
  `GWW_CHECK(a_load_free, out_load, out_free, "load into busy output register")
  `GWW_CHECK(a_load_single, 1'b1, $onehot0(out_loads), "two output loads at once")
  `GWW_CHECK_NEXT(a_accept_rewinds, cmd.accept, idx_r == '0, "release index not rewound")

endmodule

`default_nettype wire

// ===== design/greedy_word_wrap_unit.sv =====
// top level of the greedy word wrap unit
//
//   group  dir  handshake          payload
//   in_    in   tvalid/tready      tdata[7:0] char_code, tdata[15:8] char_width
//   out_   out  tvalid/tready      tdata[7:0] out_char, tlast last_of_run
//   cfg_   in   wr_en              addr 0 line_width, 1 char_spacing
//
// a char that goes straight out is accepted, then loaded into the output register
// a leading newline or space adds one output load; each held char released
// takes one hold store read and one output load
// reset is synchronous; the hold store is not cleared, only its count
// a low out_tready stalls the sequencer at the output register; the next char
// is taken while the final result of the previous one still waits
`default_nettype none

module greedy_word_wrap_unit import gww_pkg::*; #(
  parameter int HOLD_DEPTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic              cfg_addr,
  input  wire logic [LW_W-1:0]   cfg_wr_data,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [15:0]       in_tdata,   // [7:0] char_code, [15:8] char_width
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [CHAR_W-1:0] out_tdata,  // [7:0] out_char
  output logic                   out_tlast
);

  gww_cmd_t cmd;
  gww_sts_t sts;

  gww_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gww_dp #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

`default_nettype wire
